FILE: hw/rtl/gwm_pkg.sv
// Shared types, constants and helpers for the glob wildcard matcher.
// No dependencies; every other file in hw/rtl imports this package.
package gwm_pkg;

  // Pattern positions held by the cell row (accept cell comes on top)
  localparam int NPOS     = 16;
  // Positions that have register bits behind them
  localparam int REG_POS  = 16;
  localparam int LEN_W    = $clog2(NPOS + 1);
  localparam int CFG_W    = 64;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHARS_LO = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHARS_HI = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KINDS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IGNCASE  = 3'd4;

  // Position kinds; the unused code acts as a literal
  typedef enum logic [1:0] {
    KIND_LIT = 2'd0,
    KIND_ONE = 2'd1,
    KIND_RUN = 2'd2
  } kind_t;

  // Per-cell pattern setup
  typedef struct packed {
    logic [7:0] chr;
    logic [1:0] kind;
    logic       used;      // position below pattern length
    logic       in_range;  // position at or below pattern length
    logic       is_start;  // position zero
    logic       is_accept; // position equal to pattern length
  } pos_cfg_t;

  // Per-beat control broadcast to every cell
  typedef struct packed {
    logic take;     // beat accepted this cycle
    logic no_char;  // beat carries no character
    logic restart;  // last beat: return to the start set
    logic ign_case;
  } step_ctl_t;

  // Hand-off from one cell to the next position up
  typedef struct packed {
    logic c_carry;  // star closure before the character
    logic adv;      // position consumed the character
    logic d_carry;  // star closure after the character
  } link_t;

  // ASCII upper-case folding
  function automatic logic [7:0] fold8(input logic [7:0] c, input logic ign);
    logic [7:0] r;
    r = c;
    if (ign && (c >= 8'h61) && (c <= 8'h7A)) begin
      r = c - 8'h20;
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/glob_wildcard_match.sv
// Glob wildcard matcher top level: configuration registers, cell row and
// result register. Depends on gwm_pkg and gwm_cell.
//
// Usage: load the pattern through the cfg_ port (cfg_we, cfg_index,
// cfg_wdata) while no string is in flight. Stream a subject string one
// character per beat on in_tdata; in_tlast marks the final beat and
// in_tuser flags a beat with no character (an empty string is a single
// beat with in_tuser and in_tlast high). Each position cell updates its
// active flag in the cycle the beat is taken, so the block accepts one
// beat every cycle. The verdict of a string leaves on out_tdata[0] in the
// cycle after its last beat is taken; no beat comes out for other beats.
// The result sits in an output register: while out_tready is low and a
// verdict is waiting, in_tready drops, otherwise beats keep flowing.
// Reset zeroes all but out_match_r (empty pattern, case-sensitive) and
// sets the active set to the start position; no clearing pass is needed.
module glob_wildcard_match
  import gwm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // Configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  // Subject characters
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [7:0] ch
  input  logic                 in_tlast,
  input  logic                 in_tuser,   // [0] no_char
  // Verdicts
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata   // [0] matched, [7:1] zero
);

  logic [63:0] chars_lo_r;
  logic [63:0] chars_hi_r;
  logic [31:0] kinds_r;
  logic [4:0]  len_r;
  logic        ign_r;

  logic [LEN_W-1:0] len_eff;
  logic [2*REG_POS*4-1:0] chars_all;
  step_ctl_t ctl;
  logic [7:0] ch_fold;
  link_t     links [0:NPOS+1];
  logic [NPOS:0] hits;
  logic      verdict;
  logic      take;

  logic out_valid_r;
  logic out_valid_nxt;
  logic out_match_r;
  logic out_match_nxt;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chars_lo_r <= '0;
      chars_hi_r <= '0;
      kinds_r    <= '0;
      len_r      <= '0;
      ign_r      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CHARS_LO: chars_lo_r <= cfg_wdata[63:0];
        CFG_CHARS_HI: chars_hi_r <= cfg_wdata[63:0];
        CFG_KINDS:    kinds_r    <= cfg_wdata[31:0];
        CFG_LENGTH:   len_r      <= cfg_wdata[4:0];
        CFG_IGNCASE:  ign_r      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Pattern length saturated to the row size
  assign len_eff = (32'(len_r) > NPOS) ? LEN_W'(NPOS) : LEN_W'(len_r);
  assign chars_all = {chars_hi_r, chars_lo_r};

  // Beat control
  assign in_tready   = ~out_valid_r | out_tready;
  assign take        = in_tvalid & in_tready;
  assign ctl.take    = take;
  assign ctl.no_char = in_tuser;
  assign ctl.restart = in_tlast;
  assign ctl.ign_case = ign_r;
  assign ch_fold     = fold8(in_tdata, ign_r);

  assign links[0] = '0;

  // Cell row: positions 0..NPOS-1 plus position NPOS, the accept cell of a full-length pattern
  for (genvar i = 0; i <= NPOS; i++) begin : g_cell
    pos_cfg_t pcfg;

    if (i < REG_POS) begin : g_reg
      assign pcfg.chr  = chars_all[8*i +: 8];
      assign pcfg.kind = kinds_r[2*i +: 2];
    end else begin : g_fixed
      assign pcfg.chr  = 8'h00;
      assign pcfg.kind = KIND_LIT;
    end
    assign pcfg.used      = (i < 32'(len_eff));
    assign pcfg.in_range  = (i <= 32'(len_eff));
    assign pcfg.is_start  = (i == 0);
    assign pcfg.is_accept = (i == 32'(len_eff));

    gwm_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cfg     (pcfg),
      .ctl     (ctl),
      .ch_fold (ch_fold),
      .lin     (links[i]),
      .lout    (links[i+1]),
      .hit     (hits[i])
    );
  end

  assign verdict = |hits;

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_match_nxt = out_match_r;
    if (take && in_tlast) begin
      out_valid_nxt = 1'b1;
      out_match_nxt = verdict;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_match_r <= out_match_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_match_r};

  // links[NPOS+1] leaves the accept cell and goes nowhere
  logic unused_tail;
  assign unused_tail = ^links[NPOS+1];

endmodule

FILE: hw/rtl/gwm_cell.sv
// One pattern position of the matcher row: holds its active flag and
// passes closure and advance bits to the next position. Uses gwm_pkg.
module gwm_cell
  import gwm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  pos_cfg_t   cfg,
  input  step_ctl_t  ctl,
  input  logic [7:0] ch_fold,
  input  link_t      lin,
  output link_t      lout,
  output logic       hit
);

  logic act_r;
  logic act_nxt;
  logic a_in;
  logic c_bit;
  logic n_bit;
  logic d_bit;
  logic val;
  logic star;
  logic match;

  // Decode the position kind
  always_comb begin
    star  = 1'b0;
    match = 1'b0;
    case (kind_t'(cfg.kind))
      KIND_RUN: star  = 1'b1;
      KIND_ONE: match = 1'b1;
      default:  match = (fold8(cfg.chr, ctl.ign_case) == ch_fold);
    endcase
  end

  // Closure, advance and closure again
  always_comb begin
    a_in  = act_r & cfg.in_range;
    c_bit = a_in | lin.c_carry;
    n_bit = (c_bit & star & cfg.used) | lin.adv;
    d_bit = n_bit | lin.d_carry;
    val   = ctl.no_char ? c_bit : d_bit;

    lout.c_carry = c_bit & star & cfg.used;
    lout.adv     = c_bit & ~star & match & cfg.used;
    lout.d_carry = d_bit & star & cfg.used;

    hit = val & cfg.is_accept;
  end

  // Active flag update
  always_comb begin
    act_nxt = act_r;
    if (ctl.take) begin
      act_nxt = ctl.restart ? cfg.is_start : val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= cfg.is_start;
    end else begin
      act_r <= act_nxt;
    end
  end

endmodule
